FILE: sv/broc_pkg.sv
// shared constants, register codes and window helpers for the ring opening check
package broc_pkg;

    localparam int DIM_W        = 11;
    localparam int DIM_MIN      = 3;
    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;
    localparam int DATA_W       = 8;
    localparam int CFG_IDX_W    = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'b1;

    // 3x3 window, bit = row * 3 + col, row 0 and col 0 the oldest
    localparam logic [8:0] RING_MASK = 9'h1EF;
    localparam logic [8:0] KEEP_MASK = 9'h0DB;

    typedef logic [8:0] window_t;

    // shift the window one column left and bring in a new right column
    function automatic window_t push_column(window_t w, logic top, logic mid, logic bot);
        window_t res;
        res = (w >> 1) & KEEP_MASK;
        res[2] = top;
        res[5] = mid;
        res[8] = bot;
        return res;
    endfunction

    // any centre flag around offset (dr, dc), the offset itself excluded
    function automatic logic covered(window_t cw, int dr, int dc);
        logic hit;
        int   rr;
        int   cc;
        hit = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                rr = dr + i;
                cc = dc + j;
                if (!(i == 1 && j == 1) && rr < 3 && cc < 3)
                begin
                    if (cw[rr * 3 + cc])
                    begin
                        hit = 1'b1;
                    end
                end
            end
        end
        return hit;
    endfunction

    // a set pixel with no centre next to it; edge rows and columns at frame end
    function automatic logic window_fail(window_t pw, window_t cw, logic last_row,
                                         logic last_col);
        logic fail;
        int   dr_max;
        int   dc_max;
        fail   = 1'b0;
        dr_max = last_row ? 2 : 0;
        dc_max = last_col ? 2 : 0;
        for (int dr = 0; dr < 3; dr++)
        begin
            for (int dc = 0; dc < 3; dc++)
            begin
                if (dr <= dr_max && dc <= dc_max)
                begin
                    if (pw[dr * 3 + dc] && !covered(cw, dr, dc))
                    begin
                        fail = 1'b1;
                    end
                end
            end
        end
        return fail;
    endfunction

endpackage

FILE: sv/binary_ring_opening_check.sv
// top level of the binary ring opening check with line-store memories
// Binary ring opening check.
// Input stream s_axis: one pixel per transfer in raster order, tdata[0] = pixel.
// Output stream m_axis: one transfer per frame after the last pixel,
// tdata[0] = forgeable (1 when ring stamps of all centres rebuild the image).
// Config channel cfg: index 0 = image_rows, index 1 = image_cols, values clamped
// to 3..MAX; write only while no frame is in flight. cfg_ready is always high.
// Pipeline: on the accepting edge the pixel and centre line memories are read
// into registers; in the second stage the windows are shifted, the centre flag
// and coverage checks are formed and both lines are written back. One pixel per
// cycle sustained unless a frame's last pixel waits on the output; the verdict
// is registered as that pixel leaves the second stage. Consecutive pixels
// always touch different columns, so a read never hits the column being written.
// Reset clears the counters, windows and output register and sets both sizes
// to 3; line memories are not cleared, the border rule masks stale entries.
// When m_axis stalls, the verdict is held and pixels keep flowing until the
// next frame's last pixel, which waits for the previous verdict to be taken.
module binary_ring_opening_check #(
    parameter int MAX_COLS = broc_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = broc_pkg::MAX_ROWS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [broc_pkg::DATA_W-1:0]    s_axis_tdata,   // [0] pixel, rest zero
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [broc_pkg::DATA_W-1:0]    m_axis_tdata,   // [0] forgeable, rest zero
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [broc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [broc_pkg::DIM_W-1:0]     cfg_data
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    // frame size registers
    logic [broc_pkg::DIM_W-1:0] rows_reg;
    logic [broc_pkg::DIM_W-1:0] cols_reg;
    logic [broc_pkg::DIM_W-1:0] rows_clamped;
    logic [broc_pkg::DIM_W-1:0] cols_clamped;

    // raster position of the next pixel
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;

    // line memories, bit 0 the older row, bit 1 the newer row
    logic [1:0] pix_mem [MAX_COLS];
    logic [1:0] cen_mem [MAX_COLS];
    logic [1:0] pix_rd_reg;
    logic [1:0] cen_rd_reg;

    // second stage
    logic          s1_valid_reg;
    logic          s1_px_reg;
    logic [CW-1:0] s1_col_reg;
    logic [CW-1:0] s1_k_reg;
    logic          s1_c_ge1_reg;
    logic          s1_c_ge2_reg;
    logic          s1_r_ge2_reg;
    logic          s1_r_ge3_reg;
    logic          s1_r_ge4_reg;
    logic          s1_last_col_reg;
    logic          s1_last_row_reg;

    // frame state
    broc_pkg::window_t pw_reg;
    broc_pkg::window_t pw_next;
    broc_pkg::window_t cw_reg;
    broc_pkg::window_t cw_next;
    logic              match_reg;
    logic              match_next;

    // output register
    logic out_valid_reg;
    logic out_data_reg;

    logic accept;
    logic b_adv;
    logic s1_final;
    logic last_col;
    logic last_row;
    logic centre;
    logic u_bit;
    logic v_bit;
    logic fail;

    // ---------------------------------------------------------------- config
    always_comb
    begin
        if (cfg_data < broc_pkg::DIM_W'(broc_pkg::DIM_MIN))
        begin
            rows_clamped = broc_pkg::DIM_W'(broc_pkg::DIM_MIN);
        end
        else if (32'(cfg_data) > MAX_ROWS)
        begin
            rows_clamped = broc_pkg::DIM_W'(MAX_ROWS);
        end
        else
        begin
            rows_clamped = cfg_data;
        end

        if (cfg_data < broc_pkg::DIM_W'(broc_pkg::DIM_MIN))
        begin
            cols_clamped = broc_pkg::DIM_W'(broc_pkg::DIM_MIN);
        end
        else if (32'(cfg_data) > MAX_COLS)
        begin
            cols_clamped = broc_pkg::DIM_W'(MAX_COLS);
        end
        else
        begin
            cols_clamped = cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= broc_pkg::DIM_W'(broc_pkg::DIM_MIN);
            cols_reg <= broc_pkg::DIM_W'(broc_pkg::DIM_MIN);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                broc_pkg::REG_IMAGE_ROWS: rows_reg <= rows_clamped;
                broc_pkg::REG_IMAGE_COLS: cols_reg <= cols_clamped;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------ handshakes
    assign s1_final      = s1_last_col_reg && s1_last_row_reg;
    // the last pixel of a frame waits only for a free output register
    assign b_adv         = s1_valid_reg && !(s1_final && out_valid_reg && !m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || b_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------- raster counters
    assign last_col = (32'(col_reg) + 32'd1) >= 32'(cols_reg);
    assign last_row = (32'(row_reg) + 32'd1) >= 32'(rows_reg);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (!last_col)
            begin
                col_next = col_reg + 1'b1;
            end
            else
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // stage payload, border flags worked out here to keep the next stage short
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg       <= s_axis_tdata[0];
            s1_col_reg      <= col_reg;
            s1_k_reg        <= col_reg - 1'b1;
            s1_c_ge1_reg    <= 32'(col_reg) >= 32'd1;
            s1_c_ge2_reg    <= 32'(col_reg) >= 32'd2;
            s1_r_ge2_reg    <= 32'(row_reg) >= 32'd2;
            s1_r_ge3_reg    <= 32'(row_reg) >= 32'd3;
            s1_r_ge4_reg    <= 32'(row_reg) >= 32'd4;
            s1_last_col_reg <= last_col;
            s1_last_row_reg <= last_row;
        end
    end

    // ---------------------------------------------------------- line memories
    // read on the accepting edge, write back when the second stage advances
    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            pix_mem[s1_col_reg] <= {s1_px_reg, pix_rd_reg[1]};
        end
        if (accept)
        begin
            pix_rd_reg <= pix_mem[col_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv && s1_c_ge1_reg)
        begin
            cen_mem[s1_k_reg] <= {centre, v_bit};
        end
        if (accept)
        begin
            cen_rd_reg <= cen_mem[col_reg - 1'b1];
        end
    end

    // ------------------------------------------------------ window and check
    always_comb
    begin
        pw_next = broc_pkg::push_column(pw_reg, pix_rd_reg[0], pix_rd_reg[1], s1_px_reg);
        centre  = s1_r_ge2_reg && s1_c_ge2_reg
                  && ((pw_next & broc_pkg::RING_MASK) == broc_pkg::RING_MASK);
        // centre rows two and three back only exist once the frame is deep enough
        u_bit   = s1_r_ge4_reg && cen_rd_reg[0];
        v_bit   = s1_r_ge3_reg && cen_rd_reg[1];
        cw_next = broc_pkg::push_column(cw_reg, s1_c_ge2_reg && u_bit,
                                        s1_c_ge2_reg && v_bit, s1_c_ge2_reg && centre);
        fail    = s1_r_ge2_reg && s1_c_ge2_reg
                  && broc_pkg::window_fail(pw_next, cw_next, s1_last_row_reg,
                                           s1_last_col_reg);
        match_next = match_reg && !fail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pw_reg    <= '0;
            cw_reg    <= '0;
            match_reg <= 1'b1;
        end
        else if (b_adv)
        begin
            if (s1_final)
            begin
                // frame restart
                pw_reg    <= '0;
                cw_reg    <= '0;
                match_reg <= 1'b1;
            end
            else
            begin
                pw_reg    <= pw_next;
                cw_reg    <= cw_next;
                match_reg <= match_next;
            end
        end
    end

    // ------------------------------------------------------- verdict register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (b_adv && s1_final)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv && s1_final)
        begin
            out_data_reg <= match_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(broc_pkg::DATA_W - 1){1'b0}}, out_data_reg};

`ifndef NO_ASSERTIONS
    // a pixel read never lands on the column being written back
    a_no_col_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_valid_reg) |-> (col_reg != s1_col_reg))
        else $error("line memory read and write-back hit the same column");

    // the second stage only holds for a frame end meeting a full output register
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !b_adv) |-> (s1_final && out_valid_reg))
        else $error("second stage stalled without a pending verdict");

    // a frame end shows a verdict and restarts the frame state
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && s1_final) |=> (out_valid_reg && match_reg && pw_reg == '0 && cw_reg == '0))
        else $error("frame end did not deliver a verdict and restart");

    // frame sizes stay within the clamped range
    a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cols_reg) >= broc_pkg::DIM_MIN && 32'(cols_reg) <= MAX_COLS
         && 32'(rows_reg) >= broc_pkg::DIM_MIN && 32'(rows_reg) <= MAX_ROWS))
        else $error("frame size register out of range");
`endif

endmodule
